// ===== design/pie_pkg.sv =====
`default_nettype none

package pie_pkg;

  localparam int SIZE_DEF = 5;

  // datapath widths
  localparam int VW      = 32;          // Q2.30 vector component
  localparam int PW      = 48;          // Q32.16 product / eigenvalue
  localparam int ACC_W   = 56;          // accumulator, covers 16 terms of 2^49
  localparam int MA_W    = 48;
  localparam int MB_W    = 32;
  localparam int MP_W    = 80;
  localparam int DS_W    = 64;

  localparam logic [31:0]          TOL_RST = 32'd429;
  localparam logic [15:0]          LIM_RST = 16'd1000;
  localparam logic signed [PW-1:0] ONE_Q16 = 48'sd65536;

  // status codes
  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // configuration register indexes
  localparam logic CFG_TOL = 1'b0;
  localparam logic CFG_LIM = 1'b1;

  typedef enum logic {DS_SQRT, DS_DIV} ds_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ITER, S_MAX, S_SHIFT, S_SQ, S_SQ_W, S_SQRT, S_SQRT_W,
    S_DIV, S_DIV_W, S_MV_RD, S_MV_MUL, S_MV_W, S_RQ, S_RQ_W, S_CHK,
    S_TOL_W, S_OUT
  } pie_state_t;

  typedef struct packed {
    logic              mode;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] entry_value;
  } pie_in_t;

  typedef struct packed {
    logic [2:0]         component_index;
    logic signed [31:0] component;
    logic signed [31:0] eigenvalue;
    logic [1:0]         status;
    logic [15:0]        iterations_used;
    logic               last;
  } pie_out_t;

  typedef struct packed {
    logic            go;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [MP_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic            go;
    ds_op_t          op;
    logic [DS_W-1:0] num;
    logic [31:0]     den;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } ds_rsp_t;

  function automatic logic signed [PW-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W-PW){1'b0}}, 1'b0, {(PW-1){1'b1}}};
    lo_lim = {{(ACC_W-PW){1'b1}}, 1'b1, {(PW-1){1'b0}}};
    if (v > hi_lim) begin
      sat48 = hi_lim[PW-1:0];
    end else if (v < lo_lim) begin
      sat48 = lo_lim[PW-1:0];
    end else begin
      sat48 = v[PW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/power_iteration_eigen_top.sv =====
`default_nettype none

// Dominant eigenvalue by the power method, fixed point.
//
// Input channel: item is taken when start is high and busy is low.
//   mode 0 writes one Q16.16 matrix entry (row, col); rows or columns of
//   SIZE or more are dropped. Busy stays low during a load.
//   mode 1 runs the power method from an all-ones vector; busy is high for
//   the whole run, and no item is taken meanwhile.
// Result channel: after a run, SIZE results come out back to back, each
//   marked by result_valid for one cycle; last flags the final component.
//   The receiver cannot stall the block.
// Config channel: cfg_ready is always high; index 0 = tolerance (Q0.32),
//   index 1 = iteration limit. Write only while the block is idle.
// The cost of one iteration is set by the bit-serial divide/sqrt unit (one per
//   component plus one sqrt) and the shared two-pass multiplier (one product
//   per matrix entry). A run repeats this for every iteration used, then
//   outputs the SIZE results.
// Reset: synchronous; clears the matrix (per-entry valid bits), restores the
//   default tolerance and limit, and returns to idle.
module power_iteration_eigen_top import pie_pkg::*; #(
  parameter int SIZE = SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire pie_in_t     item,
  output logic             result_valid,
  output pie_out_t         result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int VI_W   = $clog2(SIZE);
  localparam int MDEPTH = SIZE * SIZE;
  localparam int ADDR_W = $clog2(MDEPTH);
  localparam logic [VI_W-1:0] LAST_I = VI_W'(SIZE - 1);

  pie_state_t state, state_next;

  logic [VI_W-1:0]          idx;
  logic [VI_W-1:0]          kdx;
  logic [VI_W-1:0]          vsel;
  logic [ADDR_W-1:0]        addr;
  logic signed [VW-1:0]     cur  [SIZE];
  logic signed [PW-1:0]     prod [SIZE];
  logic [PW-1:0]            mx;
  logic [PW-1:0]            smx;
  logic [4:0]               rsh;
  logic [4:0]               lsh;
  logic [63:0]              sumsq;
  logic [31:0]              nrm;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PW-1:0]     prev_ev;
  logic signed [PW-1:0]     latest_ev;
  logic [15:0]              count;
  logic [1:0]               status;
  logic [31:0]              tol;
  logic [15:0]              lim;
  logic                     neg_r;

  // matrix memory
  logic [31:0]       mem [MDEPTH];
  logic [MDEPTH-1:0] mvalid;
  logic [31:0]       memq;
  logic              memv;
  logic              we;
  logic [ADDR_W-1:0] waddr;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  ds_req_t  ds_req;
  ds_rsp_t  ds_rsp;

  // datapath views
  logic signed [VW-1:0]    cur_sel;
  logic signed [PW-1:0]    prod_sel;
  logic [PW-1:0]           pu, prod_mag;
  logic [31:0]             cu, cur_mag;
  logic [31:0]             entry, entry_mag;
  logic [PW-1:0]           shr, shl;
  logic [28:0]             m_scaled;
  logic [PW-1:0]           mx_new;
  logic [49:0]             tq;
  logic signed [ACC_W-1:0] tq_ext, term, acc_sum;
  logic signed [48:0]      dif;
  logic [48:0]             du, dmag;
  logic [PW-1:0]           lu, lmag;
  logic                    conv;
  logic                    at_limit;
  logic signed [31:0]      ev_sat;

  pie_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  pie_divsqrt u_ds (.clk(clk), .rst(rst), .req(ds_req), .rsp(ds_rsp));

  // one read port into the vector registers: column index while doing A*x
  assign vsel     = (state == S_MV_MUL) ? kdx : idx;
  assign cur_sel  = cur[vsel];
  assign prod_sel = prod[idx];

  assign pu       = prod_sel;
  assign prod_mag = pu[PW-1] ? (~pu + 48'd1) : pu;
  assign cu       = cur_sel;
  assign cur_mag  = cu[31] ? (~cu + 32'd1) : cu;
  assign entry    = memv ? memq : 32'd0;
  assign entry_mag = entry[31] ? (~entry + 32'd1) : entry;

  // scale so the largest magnitude lands in [2^28, 2^29)
  assign shr      = prod_mag >> rsh;
  assign shl      = shr << lsh;
  assign m_scaled = shl[28:0];
  assign mx_new   = (prod_mag > mx) ? prod_mag : mx;

  // truncated Q30 product, signed, accumulated
  assign tq      = mul_rsp.p[79:30];
  assign tq_ext  = {{(ACC_W-50){1'b0}}, tq};
  assign term    = neg_r ? -tq_ext : tq_ext;
  assign acc_sum = acc + term;

  // relative change test: |new - old| * 2^32 <= tol * |new|
  assign dif  = {latest_ev[PW-1], latest_ev} - {prev_ev[PW-1], prev_ev};
  assign du   = dif;
  assign dmag = du[48] ? (~du + 49'd1) : du;
  assign lu   = latest_ev;
  assign lmag = lu[PW-1] ? (~lu + 48'd1) : lu;
  assign conv = {dmag, 32'b0} <= {1'b0, mul_rsp.p};
  assign at_limit = (count >= lim) || (count == 16'hFFFF);

  always_comb begin
    if (latest_ev > 48'sh0000_7FFF_FFFF) begin
      ev_sat = 32'sh7FFF_FFFF;
    end else if (latest_ev < 48'shFFFF_8000_0000) begin
      ev_sat = 32'sh8000_0000;
    end else begin
      ev_sat = latest_ev[31:0];
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT);
  assign result       = '{component_index: 3'(idx), component: cur_sel,
                          eigenvalue: ev_sat, status: status,
                          iterations_used: count, last: (idx == LAST_I)};
  assign cfg_ready    = 1'b1;

  assign we    = (state == S_IDLE) && start && !item.mode &&
                 (32'(item.row) < SIZE) && (32'(item.col) < SIZE);
  assign waddr = ADDR_W'(32'(item.row) * SIZE + 32'(item.col));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= item.entry_value;
    end
    memq <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvalid <= '0;
      memv   <= 1'b0;
    end else begin
      if (we) begin
        mvalid[waddr] <= 1'b1;
      end
      memv <= mvalid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and unit requests
  always_comb begin
    state_next = state;
    mul_req    = '0;
    ds_req     = '0;
    case (state)
      S_IDLE: begin
        if (start && item.mode) begin
          state_next = S_ITER;
        end
      end
      S_ITER: state_next = S_MAX;
      S_MAX: begin
        if (idx == LAST_I) begin
          state_next = (mx_new == '0) ? S_OUT : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if ((smx[47:29] == '0) && smx[28]) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        mul_req    = '{go: 1'b1, a: {19'b0, m_scaled}, b: {3'b0, m_scaled}};
        state_next = S_SQ_W;
      end
      S_SQ_W: begin
        if (mul_rsp.done) begin
          state_next = (idx == LAST_I) ? S_SQRT : S_SQ;
        end
      end
      S_SQRT: begin
        ds_req     = '{go: 1'b1, op: DS_SQRT, num: sumsq, den: 32'd0};
        state_next = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (ds_rsp.done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ds_req     = '{go: 1'b1, op: DS_DIV, num: {5'b0, m_scaled, 30'b0}, den: nrm};
        state_next = S_DIV_W;
      end
      S_DIV_W: begin
        if (ds_rsp.done) begin
          state_next = (idx == LAST_I) ? S_MV_RD : S_DIV;
        end
      end
      S_MV_RD: state_next = S_MV_MUL;
      S_MV_MUL: begin
        mul_req    = '{go: 1'b1, a: {16'b0, entry_mag}, b: cur_mag};
        state_next = S_MV_W;
      end
      S_MV_W: begin
        if (mul_rsp.done) begin
          state_next = ((kdx == LAST_I) && (idx == LAST_I)) ? S_RQ : S_MV_RD;
        end
      end
      S_RQ: begin
        mul_req    = '{go: 1'b1, a: prod_mag, b: cur_mag};
        state_next = S_RQ_W;
      end
      S_RQ_W: begin
        if (mul_rsp.done) begin
          state_next = (idx == LAST_I) ? S_CHK : S_RQ;
        end
      end
      S_CHK: begin
        if (latest_ev == '0) begin
          state_next = S_OUT;
        end else begin
          mul_req    = '{go: 1'b1, a: lmag, b: tol};
          state_next = S_TOL_W;
        end
      end
      S_TOL_W: begin
        if (mul_rsp.done) begin
          state_next = (conv || at_limit) ? S_OUT : S_ITER;
        end
      end
      S_OUT: begin
        if (idx == LAST_I) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RST;
      lim       <= LIM_RST;
      idx       <= '0;
      kdx       <= '0;
      addr      <= '0;
      count     <= '0;
      status    <= ST_CONV;
      prev_ev   <= '0;
      latest_ev <= '0;
      for (int i = 0; i < SIZE; i++) begin
        cur[i]  <= '0;
        prod[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOL) begin
          tol <= cfg_data;
        end else begin
          lim <= cfg_data[15:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (start && item.mode) begin
            for (int i = 0; i < SIZE; i++) begin
              prod[i] <= ONE_Q16;
            end
            latest_ev <= ONE_Q16;
            count     <= '0;
          end
        end
        S_ITER: begin
          prev_ev <= latest_ev;
          idx     <= '0;
          mx      <= '0;
        end
        S_MAX: begin
          mx <= mx_new;
          if (idx == LAST_I) begin
            idx <= '0;
            smx <= mx_new;
            rsh <= '0;
            lsh <= '0;
            if (mx_new == '0) begin
              status <= ST_ZERO;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT: begin
          if (smx[47:29] != '0) begin
            smx <= smx >> 1;
            rsh <= rsh + 5'd1;
          end else if (!smx[28]) begin
            smx <= smx << 1;
            lsh <= lsh + 5'd1;
          end else begin
            sumsq <= '0;
            idx   <= '0;
          end
        end
        S_SQ_W: begin
          if (mul_rsp.done) begin
            sumsq <= sumsq + mul_rsp.p[63:0];
            idx   <= (idx == LAST_I) ? '0 : idx + 1'b1;
          end
        end
        S_SQRT_W: begin
          if (ds_rsp.done) begin
            nrm <= ds_rsp.res;
            idx <= '0;
          end
        end
        S_DIV_W: begin
          if (ds_rsp.done) begin
            cur[idx] <= prod_sel[PW-1] ? -$signed(ds_rsp.res) : $signed(ds_rsp.res);
            if (idx == LAST_I) begin
              count <= count + 16'd1;
              idx   <= '0;
              kdx   <= '0;
              addr  <= '0;
              acc   <= '0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_MV_MUL: neg_r <= entry[31] ^ cur_sel[VW-1];
        S_MV_W: begin
          if (mul_rsp.done) begin
            addr <= addr + 1'b1;
            if (kdx == LAST_I) begin
              prod[idx] <= sat48(acc_sum);
              acc       <= '0;
              kdx       <= '0;
              idx       <= (idx == LAST_I) ? '0 : idx + 1'b1;
            end else begin
              acc <= acc_sum;
              kdx <= kdx + 1'b1;
            end
          end
        end
        S_RQ: neg_r <= prod_sel[PW-1] ^ cur_sel[VW-1];
        S_RQ_W: begin
          if (mul_rsp.done) begin
            if (idx == LAST_I) begin
              latest_ev <= sat48(acc_sum);
              idx       <= '0;
            end else begin
              acc <= acc_sum;
              idx <= idx + 1'b1;
            end
          end
        end
        S_CHK: begin
          if (latest_ev == '0) begin
            status <= ST_ZERO;
          end
        end
        S_TOL_W: begin
          if (mul_rsp.done) begin
            if (conv) begin
              status <= ST_CONV;
            end else if (at_limit) begin
              status <= ST_LIMIT;
            end
          end
        end
        S_OUT: idx <= (idx == LAST_I) ? '0 : idx + 1'b1;
        default: ;
      endcase
    end
  end

  // a run only begins on an accepted start item
  a_run_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.mode))
    else $error("run began without a start transfer");

  // components come out back to back in index order
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=>
      (result_valid && (result.component_index ==
                        3'($past(result.component_index) + 3'd1))))
    else $error("result burst broken or out of order");

  // last component ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !busy)
    else $error("still busy after last result");

  // multiplier answers only where the sequencer waits for it
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_SQ_W || state == S_MV_W ||
                      state == S_RQ_W || state == S_TOL_W))
    else $error("multiplier result with no waiting state");

endmodule

`default_nettype wire

// ===== design/pie_mul.sv =====
`default_nettype none

// 48x32 unsigned multiply, exact 80-bit product, one 24x32 multiplier used twice
module pie_mul import pie_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [MA_W-1:0] a;
  logic [MB_W-1:0] b;
  logic [1:0]      cnt;
  logic            run;
  logic [55:0]     lo;
  logic [55:0]     hi;
  logic [23:0]     opnd;
  logic [55:0]     mprod;

  assign opnd  = (cnt == 2'd0) ? a[23:0] : a[47:24];
  assign mprod = {32'b0, opnd} * {24'b0, b};

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      cnt      <= 2'd0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        a   <= req.a;
        b   <= req.b;
        cnt <= 2'd0;
        run <= 1'b1;
      end else if (run) begin
        case (cnt)
          2'd0: begin
            lo  <= mprod;
            cnt <= 2'd1;
          end
          2'd1: begin
            hi  <= mprod;
            cnt <= 2'd2;
          end
          default: begin
            rsp.p    <= {hi, 24'b0} + {24'b0, lo};
            rsp.done <= 1'b1;
            run      <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/pie_divsqrt.sv =====
`default_nettype none

// bit-serial unit: floor square root (32 steps) or restoring divide (31 steps)
module pie_divsqrt import pie_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire ds_req_t req,
  output ds_rsp_t      rsp
);

  ds_op_t          op_r;
  logic            run;
  logic            done;
  logic [5:0]      cnt;
  logic [DS_W-1:0] v;
  logic [DS_W-1:0] res;
  logic [DS_W-1:0] bitr;
  logic [DS_W-1:0] trial;
  logic [32:0]     rem;
  logic [32:0]     r2;
  logic [30:0]     sh;
  logic [30:0]     q;
  logic [31:0]     den;

  assign trial = res + bitr;
  assign r2    = {rem[31:0], sh[30]};
  assign rsp   = '{done: done, res: (op_r == DS_SQRT) ? res[31:0] : {1'b0, q}};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
      op_r <= DS_SQRT;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        op_r <= req.op;
        run  <= 1'b1;
        if (req.op == DS_SQRT) begin
          v    <= req.num;
          res  <= '0;
          bitr <= {2'b01, {(DS_W-2){1'b0}}};
          cnt  <= 6'd32;
        end else begin
          rem <= req.num[63:31];
          sh  <= req.num[30:0];
          q   <= '0;
          den <= req.den;
          cnt <= 6'd31;
        end
      end else if (run) begin
        if (op_r == DS_SQRT) begin
          if (v >= trial) begin
            v   <= v - trial;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
        end else begin
          if (r2 >= {1'b0, den}) begin
            rem <= r2 - {1'b0, den};
            q   <= {q[29:0], 1'b1};
          end else begin
            rem <= r2;
            q   <= {q[29:0], 1'b0};
          end
          sh <= {sh[29:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_power_iteration_eigen_top.sv =====
`default_nettype none

module tb_power_iteration_eigen_top;
  import pie_pkg::*;

  localparam int N = SIZE_DEF;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;
  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint ONE_FX = 65536;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pie_in_t     item;
  logic        result_valid;
  pie_out_t    result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  power_iteration_eigen_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block: matrix, vectors, eigenvalues, registers.
  longint      mat_shadow [N*N];
  longint      unit_vec [N];
  longint      prod_vec [N];
  longint      lambda_old;
  longint      lambda_new;
  logic [15:0] iter_cnt;
  logic [31:0] tol_reg;
  logic [15:0] lim_reg;

  pie_out_t eigvec_pending [$];

  int errors;
  int n_loads;
  int n_runs;
  int n_checked;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the shadow model
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  // truncating (a * b) >> 30, signs handled on magnitudes
  function automatic longint mul_q30(longint a, longint b);
    logic [127:0] p;
    longint q;
    p = 128'(magnitude(a)) * 128'(magnitude(b));
    q = longint'(p >> 30);
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // prod_vec -> unit_vec (Q2.30); returns 0 when the norm is zero
  function automatic bit unit_normalize();
    logic [63:0] m [N];
    logic [63:0] mx, sum, nrm, q;
    int r, l;
    mx = 0; sum = 0; r = 0; l = 0;
    for (int i = 0; i < N; i++) begin
      m[i] = magnitude(prod_vec[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while ((mx >> r) >= (64'd1 << 29)) r++;
    while ((mx << l) < (64'd1 << 28)) l++;
    for (int i = 0; i < N; i++) begin
      m[i] = (m[i] >> r) << l;
      sum += m[i] * m[i];
    end
    nrm = floor_sqrt(sum);
    for (int i = 0; i < N; i++) begin
      q = (m[i] << 30) / nrm;
      unit_vec[i] = prod_vec[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  // |new - old| * 2^32 <= tol * |new|, exact
  function automatic bit converged(longint nw, longint od);
    logic [127:0] lhs, rhs;
    lhs = 128'(magnitude(nw - od)) << 32;
    rhs = 128'(tol_reg) * 128'(magnitude(nw));
    return lhs <= rhs;
  endfunction

  // Full power-method run; queues the eigenvector results.
  task automatic predict_eigen_run();
    longint   acc;
    longint   ev;
    logic [1:0] st;
    pie_out_t r;
    for (int i = 0; i < N; i++) prod_vec[i] = ONE_FX;
    lambda_new = ONE_FX;
    iter_cnt = 0;
    forever begin
      lambda_old = lambda_new;
      if (!unit_normalize()) begin
        st = ST_ZERO;
        break;
      end
      iter_cnt++;
      for (int i = 0; i < N; i++) begin
        acc = 0;
        for (int k = 0; k < N; k++) acc += mul_q30(mat_shadow[i*N+k], unit_vec[k]);
        prod_vec[i] = clamp48(acc);
      end
      acc = 0;
      for (int i = 0; i < N; i++) acc += mul_q30(prod_vec[i], unit_vec[i]);
      lambda_new = clamp48(acc);
      if (lambda_new == 0) begin
        st = ST_ZERO;
        break;
      end
      if (converged(lambda_new, lambda_old)) begin
        st = ST_CONV;
        break;
      end
      if (iter_cnt >= lim_reg || iter_cnt == 16'hFFFF) begin
        st = ST_LIMIT;
        break;
      end
    end
    ev = lambda_new;
    if (ev > 64'sd2147483647) ev = 64'sd2147483647;
    if (ev < -64'sd2147483648) ev = -64'sd2147483648;
    for (int i = 0; i < N; i++) begin
      r.component_index = 3'(i);
      r.component = unit_vec[i][31:0];
      r.eigenvalue = ev[31:0];
      r.status = st;
      r.iterations_used = iter_cnt;
      r.last = (i == N - 1);
      eigvec_pending.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // mostly short gaps, sometimes none, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // One transfer on the command channel. With more=1 start stays high
  // when no gap follows, so back-to-back items run without a bubble.
  task automatic send_item(logic md, logic [2:0] r, logic [2:0] c, logic [31:0] v,
                           bit more);
    int g;
    start <= 1'b1;
    item  <= '{mode: md, row: r, col: c, entry_value: v};
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    if (md == MODE_LOAD) begin
      n_loads++;
      if (r < N && c < N) mat_shadow[r*N+c] = longint'(signed'(v));
    end else begin
      n_runs++;
      predict_eigen_run();
    end
    g = more ? pick_gap() : 1;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait until all results are in and the block is idle, plus slack
  task automatic drain();
    while (eigvec_pending.size() != 0 || busy) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOL) tol_reg = data;
    else lim_reg = data[15:0];
  endtask

  task automatic load_diag(longint d0, longint d1);
    for (int i = 0; i < N; i++)
      for (int k = 0; k < N; k++)
        send_item(MODE_LOAD, 3'(i), 3'(k),
                  i != k ? 32'd0 : (i == 0 ? d0[31:0] : d1[31:0]), 1);
  endtask

  // ---------------------------------------------------------------------------
  // Result check: one result per strobe, against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pie_out_t e;
    if (!rst && result_valid) begin
      if (eigvec_pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        e = eigvec_pending.pop_front();
        n_checked++;
        if (result.component_index !== e.component_index) begin
          $display("%0t: component_index exp %0d got %0d", $time,
                   e.component_index, result.component_index);
          errors++;
        end
        if (result.component !== e.component) begin
          $display("%0t: component exp %h got %h", $time, e.component, result.component);
          errors++;
        end
        if (result.eigenvalue !== e.eigenvalue) begin
          $display("%0t: eigenvalue exp %h got %h", $time, e.eigenvalue,
                   result.eigenvalue);
          errors++;
        end
        if (result.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, result.status);
          errors++;
        end
        if (result.iterations_used !== e.iterations_used) begin
          $display("%0t: iterations_used exp %0d got %0d", $time, e.iterations_used,
                   result.iterations_used);
          errors++;
        end
        if (result.last !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, result.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // cleared matrix: first product is zero, so the eigenvalue is zero
  task automatic test_cleared_matrix();
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    drain();
  endtask

  // extreme values, out-of-range positions dropped, identity converges at once
  task automatic test_loads_and_identity();
    send_item(MODE_LOAD, 3'd7, 3'd0, 32'h7FFF_FFFF, 1);
    send_item(MODE_LOAD, 3'd0, 3'd5, 32'h8000_0000, 1);
    send_item(MODE_LOAD, 3'd6, 3'd6, 32'hFFFF_FFFF, 1);
    load_diag(ONE_FX, ONE_FX);
    send_item(MODE_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF, 0);
    drain();
  endtask

  // tolerance zero; limit of zero acts as one; converge+limit together
  task automatic test_limits();
    write_reg(CFG_TOL, 32'd0);
    write_reg(CFG_LIM, 32'd0);
    load_diag(2 * ONE_FX, ONE_FX);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    write_reg(CFG_LIM, 32'd1);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    load_diag(ONE_FX, ONE_FX);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    write_reg(CFG_LIM, 32'd6);
    load_diag(-3 * ONE_FX, ONE_FX);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    drain();
  endtask

  // full-scale matrix: eigenvalue beyond Q16.16 range saturates
  task automatic test_saturation();
    write_reg(CFG_TOL, 32'hFFFF_FFFF);
    for (int i = 0; i < N*N; i++)
      send_item(MODE_LOAD, 3'(i / N), 3'(i % N), 32'h7FFF_FFFF, 1);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    for (int i = 0; i < N*N; i++)
      send_item(MODE_LOAD, 3'(i / N), 3'(i % N), 32'h8000_0000, 1);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    // largest limit with an all-zero matrix stops on the zero eigenvalue
    write_reg(CFG_LIM, 32'hFFFF);
    for (int i = 0; i < N*N; i++)
      send_item(MODE_LOAD, 3'(i / N), 3'(i % N), 32'd0, 1);
    send_item(MODE_RUN, 3'd0, 3'd0, 32'd0, 0);
    drain();
  endtask

  function automatic logic [31:0] rand_entry();
    int p;
    p = $urandom_range(99);
    if (p < 15) return $urandom();
    if (p < 25) return 32'd0;
    return 32'(signed'($urandom_range(0, 8 * ONE_FX)) - 4 * ONE_FX);
  endfunction

  // bursts of loads with random content, then a run with random registers
  task automatic test_random(int target);
    int sent;
    int nl;
    logic [2:0] r, c;
    sent = 0;
    while (sent < target) begin
      write_reg(CFG_LIM, $urandom_range(1, 10));
      case ($urandom_range(3))
        0: write_reg(CFG_TOL, $urandom());
        1: write_reg(CFG_TOL, $urandom_range(0, 100000));
        2: write_reg(CFG_TOL, TOL_RST);
        default: write_reg(CFG_TOL, $urandom_range(1 << 20, 1 << 28));
      endcase
      nl = $urandom_range(4, 25);
      for (int j = 0; j < nl; j++) begin
        if ($urandom_range(9) == 0) begin
          r = 3'($urandom());
          c = 3'($urandom());
        end else begin
          r = 3'($urandom_range(N - 1));
          c = 3'($urandom_range(N - 1));
        end
        send_item(MODE_LOAD, r, c, rand_entry(), 1);
      end
      // start drops after the run item so the block is not restarted later
      send_item(MODE_RUN, 3'($urandom()), 3'($urandom()), $urandom(), 0);
      sent += nl + 1;
    end
    start <= 1'b0;
    drain();
  endtask

  initial begin
    clk = 0;
    rst = 1;
    start = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = CFG_TOL;
    cfg_data = '0;
    errors = 0;
    n_loads = 0;
    n_runs = 0;
    n_checked = 0;
    foreach (mat_shadow[i]) mat_shadow[i] = 0;
    tol_reg = TOL_RST;
    lim_reg = LIM_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cleared_matrix();
    test_loads_and_identity();
    test_limits();
    test_saturation();
    test_random(243);

    if (eigvec_pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, eigvec_pending.size());
      errors++;
    end
    $display("Covered %0d matrix loads and %0d eigen runs; %0d results checked.",
             n_loads, n_runs, n_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: runs use small limits, so this is far beyond a correct run
  initial begin
    #(12 * 4_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/pie_pkg.sv
design/pie_mul.sv
design/pie_divsqrt.sv
design/power_iteration_eigen_top.sv
tb/tb_power_iteration_eigen_top.sv
